// File: rtl/bitmap_slot_allocator_top_macros.svh
// Assertion macros for the bitmap slot allocator.
// Used by modules that take clk and rst_n; no other dependencies.
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsa check failed");

// next-cycle implication
`define BSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsa check failed");

`endif

// File: rtl/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// No dependencies.
`default_nettype none
package bsa_pkg;
    localparam int POOL_SLOTS_DEF = 512;
    localparam int REQ_W         = 12;
    localparam int SLOT_FIELD_W  = 9;
    localparam int RUN_FIELD_W   = 10;
    localparam int NEED_W        = 10;
    localparam int SLOT_SHIFT    = 3;
    localparam int PAD_BYTES     = 9;
    localparam int RUN_FIELD_MAX = 1023;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NOFIT   = 2'd1;
    localparam status_t ST_BADFREE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_MARK,
        S_FREE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic free;
        logic mark;
    } cell_t;
endpackage
`default_nettype wire

// File: rtl/bsa_cell.sv
// One slot cell of the rotating ring: free bit and run-start mark.
// Depends on bsa_pkg.
`default_nettype none
module bsa_cell (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            shift_en,
    input  bsa_pkg::cell_t d,
    output bsa_pkg::cell_t q
);
    import bsa_pkg::*;

    cell_t q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg.free <= 1'b1;
            q_reg.mark <= 1'b0;
        end
        else if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;
endmodule
`default_nettype wire

// File: rtl/bsa_ctrl.sv
// Sequencer at the head of the ring: first-fit search, mark, free, largest-run scan.
// Holds the run length memory and the result register. Depends on bsa_pkg and macros.
`default_nettype none
`include "bitmap_slot_allocator_top_macros.svh"
module bsa_ctrl #(
    parameter int POOL_SLOTS = bsa_pkg::POOL_SLOTS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 func,
    input  wire  [bsa_pkg::REQ_W-1:0]           request_bytes,
    input  wire  [bsa_pkg::SLOT_FIELD_W-1:0]    release_slot,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [1:0]                          status,
    output logic [bsa_pkg::SLOT_FIELD_W-1:0]    start_slot,
    output logic [bsa_pkg::RUN_FIELD_W-1:0]     largest_free_run,
    output logic                                shift_en,
    input  bsa_pkg::cell_t                      head_in,
    output bsa_pkg::cell_t                      head_out
);
    import bsa_pkg::*;

    localparam int IW    = $clog2(POOL_SLOTS);
    localparam int CW    = $clog2(POOL_SLOTS + 1);
    localparam int NCW   = (CW > NEED_W) ? CW : NEED_W;
    localparam int AW    = (IW > SLOT_FIELD_W) ? IW : SLOT_FIELD_W;
    localparam int LW    = (CW > RUN_FIELD_W) ? CW : RUN_FIELD_W;
    localparam int SUM_W = REQ_W + 1;

    state_t state_reg, state_next;

    logic              func_reg;
    logic [NEED_W-1:0] need_reg;
    logic [SLOT_FIELD_W-1:0] rel_reg;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     cur_reg, cur_next;
    logic [CW-1:0]     best_reg, best_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic [IW-1:0]     first_reg, first_next;
    logic [IW-1:0]     start_reg, start_next;
    logic              found_reg, found_next;
    logic              okfree_reg, okfree_next;
    logic [CW-1:0]     largest_reg, largest_next;
    status_t           res_reg, res_next;

    logic [CW-1:0]     len_mem [POOL_SLOTS];
    logic [CW-1:0]     len_rd_reg;
    logic              mem_we;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [SLOT_FIELD_W-1:0] out_start_reg;
    logic [RUN_FIELD_W-1:0]  out_largest_reg;

    logic              in_accept, last, load_out, at_rel, at_start;
    logic [NEED_W-1:0] need_in;
    logic [CW-1:0]     need_cw;
    logic [AW-1:0]     start_ext;
    logic [LW-1:0]     largest_ext;

    assign in_accept = in_valid && !in_stall;
    assign last      = (idx_reg == IW'(POOL_SLOTS - 1));
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign need_in   = NEED_W'((SUM_W'(request_bytes) + SUM_W'(PAD_BYTES)) >> SLOT_SHIFT);
    assign need_cw   = CW'(need_reg);
    assign at_rel    = (AW'(rel_reg) == AW'(idx_reg));
    assign at_start  = (idx_reg == start_reg);
    assign start_ext = AW'(start_reg);
    assign largest_ext = LW'(largest_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_FREE)
                        state_next = S_FREE;
                    else if (NCW'(need_in) > NCW'(largest_reg))
                        state_next = S_DONE;
                    else
                        state_next = S_FIND;
                end
            end
            S_FIND: if (last) state_next = found_next ? S_MARK : S_DONE;
            S_MARK: if (last) state_next = S_DONE;
            S_FREE: if (last) state_next = S_DONE;
            S_DONE: if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        shift_en = (state_reg == S_FIND) || (state_reg == S_MARK) || (state_reg == S_FREE);
        head_out = head_in;
        mem_we   = 1'b0;
        idx_next = shift_en ? IW'(idx_reg + 1'b1) : idx_reg;
        cur_next = cur_reg;
        best_next = best_reg;
        rem_next = rem_reg;
        first_next = first_reg;
        start_next = start_reg;
        found_next = found_reg;
        okfree_next = okfree_reg;
        largest_next = largest_reg;
        res_next = res_reg;

        case (state_reg)
            S_FIND:
            begin
                if (head_in.free)
                begin
                    cur_next = CW'(cur_reg + 1'b1);
                    if (!found_reg && (NCW'(cur_next) == NCW'(need_reg)))
                    begin
                        found_next = 1'b1;
                        start_next = first_reg;
                    end
                end
                else
                begin
                    cur_next   = '0;
                    first_next = IW'(idx_reg + 1'b1);
                end
            end
            S_MARK:
            begin
                if (at_start)
                begin
                    head_out.free = 1'b0;
                    head_out.mark = 1'b1;
                    rem_next = CW'(need_cw - 1'b1);
                    mem_we   = 1'b1;
                end
                else if (rem_reg != '0)
                begin
                    head_out.free = 1'b0;
                    rem_next = CW'(rem_reg - 1'b1);
                end
            end
            S_FREE:
            begin
                if (at_rel && head_in.mark)
                begin
                    head_out.free = 1'b1;
                    head_out.mark = 1'b0;
                    rem_next = CW'(len_rd_reg - 1'b1);
                    okfree_next = 1'b1;
                end
                else if (rem_reg != '0)
                begin
                    head_out.free = 1'b1;
                    rem_next = CW'(rem_reg - 1'b1);
                end
            end
            default: ;
        endcase

        if ((state_reg == S_MARK) || (state_reg == S_FREE))
        begin
            cur_next = head_out.free ? CW'(cur_reg + 1'b1) : '0;
            if (cur_next > best_reg)
                best_next = cur_next;
            if (last)
            begin
                largest_next = best_next;
                res_next = ((state_reg == S_MARK) || okfree_next) ? ST_OK : ST_BADFREE;
            end
        end

        if ((state_reg == S_FIND) && last)
        begin
            idx_next  = '0;
            cur_next  = '0;
            best_next = '0;
            rem_next  = '0;
            if (!found_next)
                res_next = ST_NOFIT;
        end

        if (in_accept)
        begin
            idx_next    = '0;
            cur_next    = '0;
            best_next   = '0;
            rem_next    = '0;
            first_next  = '0;
            start_next  = '0;
            found_next  = 1'b0;
            okfree_next = 1'b0;
            res_next    = ST_NOFIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            len_mem[start_reg] <= need_cw;
        if (in_accept)
            len_rd_reg <= len_mem[(32'(release_slot) >= 32'(POOL_SLOTS)) ? '0
                                  : IW'(release_slot)];
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= func;
            need_reg <= need_in;
            rel_reg  <= release_slot;
        end
        idx_reg    <= idx_next;
        cur_reg    <= cur_next;
        best_reg   <= best_next;
        rem_reg    <= rem_next;
        first_reg  <= first_next;
        start_reg  <= start_next;
        found_reg  <= found_next;
        okfree_reg <= okfree_next;
        res_reg    <= res_next;
        if (load_out)
        begin
            out_status_reg <= res_reg;
            out_start_reg  <= (res_reg == ST_OK && func_reg == FUNC_ALLOC)
                              ? start_ext[SLOT_FIELD_W-1:0] : '0;
            out_largest_reg <= (largest_ext > LW'(RUN_FIELD_MAX))
                               ? RUN_FIELD_W'(RUN_FIELD_MAX) : largest_ext[RUN_FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            largest_reg   <= CW'(POOL_SLOTS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            largest_reg <= largest_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign start_slot       = out_start_reg;
    assign largest_free_run = out_largest_reg;

    `BSA_ASSERT_IMP(a_mark_free_only, (state_reg == S_MARK) && (at_start || rem_reg != '0),
                    head_in.free)
    `BSA_ASSERT_IMP(a_free_used_only, (state_reg == S_FREE) && !at_rel && (rem_reg != '0),
                    !head_in.free)
    `BSA_ASSERT_IMP(a_largest_bound, 1'b1, largest_reg <= CW'(POOL_SLOTS))
    `BSA_ASSERT_IMP(a_err_no_start, out_valid_reg && (out_status_reg != ST_OK),
                    out_start_reg == '0)
    `BSA_ASSERT_NXT(a_pass_from_idle, (state_reg == S_IDLE) && !in_valid,
                    !shift_en)
endmodule
`default_nettype wire

// File: rtl/bitmap_slot_allocator_top.sv
// Bitmap first-fit slot allocator: ring of slot cells plus head sequencer.
// Depends on bsa_pkg, bsa_cell, bsa_ctrl.
//
// Usage:
//   Request channel (in_valid/in_stall): func 0 allocates ceil((request_bytes+2)/8)
//   slots, func 1 frees the run starting at release_slot. One request at a time:
//   in_stall is high from acceptance until the result is written out.
//   Result channel (out_valid/out_stall): status, start_slot, largest_free_run.
//   Passes over the ring (one slot cell visits the head per cycle during a pass):
//     allocate that fits          : search pass, then mark+scan pass
//     allocate larger than largest: no pass
//     allocate with no first fit  : search pass only
//     free                        : release+scan pass
//   A new request is taken only once the sequencer is back in idle, which it
//   enters as the result register loads.
//   Reset: every slot free, no run starts, largest run POOL_SLOTS; no clearing pass.
//   A result waiting under out_stall holds; the next request is taken meanwhile and
//   finishes into the result register once it is taken.
`default_nettype none
module bitmap_slot_allocator_top #(
    parameter int POOL_SLOTS = bsa_pkg::POOL_SLOTS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 func,
    input  wire  [bsa_pkg::REQ_W-1:0]           request_bytes,
    input  wire  [bsa_pkg::SLOT_FIELD_W-1:0]    release_slot,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [1:0]                          status,
    output logic [bsa_pkg::SLOT_FIELD_W-1:0]    start_slot,
    output logic [bsa_pkg::RUN_FIELD_W-1:0]     largest_free_run
);
    import bsa_pkg::*;

    cell_t ring [POOL_SLOTS];
    cell_t head_out;
    logic  shift_en;

    for (genvar k = 0; k < POOL_SLOTS; k++)
    begin : g_cell
        if (k == POOL_SLOTS - 1)
        begin : g_tail
            bsa_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d        (head_out),
                .q        (ring[k])
            );
        end
        else
        begin : g_body
            bsa_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d        (ring[k+1]),
                .q        (ring[k])
            );
        end
    end

    bsa_ctrl #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .request_bytes    (request_bytes),
        .release_slot     (release_slot),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .start_slot       (start_slot),
        .largest_free_run (largest_free_run),
        .shift_en         (shift_en),
        .head_in          (ring[0]),
        .head_out         (head_out)
    );
endmodule
`default_nettype wire
